// ----- design/three_axis_pi_position_controller_core_macros.svh -----
// Assertion macros shared by the position controller modules.
`ifndef THREE_AXIS_PI_POSITION_CONTROLLER_CORE_MACROS_SVH
`define THREE_AXIS_PI_POSITION_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TAPC_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TAPC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tapc_pkg.sv -----
// Shared types and constants for the three-axis PI position controller.
`timescale 1ns / 1ps
package tapc_pkg;

  localparam int NAXES        = 3;
  localparam int ACT_W        = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int GAIN_W       = 16;
  localparam int LIMIT_W      = 31;
  localparam int DIST_W       = 32;
  localparam int DIST_SHIFT   = 16;
  localparam int VEL_W        = 32;
  localparam int FRAC_SHIFT   = 12;
  localparam int SMALL_W      = 24;
  localparam int SQ_W         = 2 * SMALL_W;
  localparam int SQSUM_W      = SQ_W + 2;
  localparam int PROD_CAP_EXP = 60;
  localparam int PROD_W       = PROD_CAP_EXP + 2;
  localparam int SUM_W        = PROD_W + 1;

  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;

  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STOP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_SQ  = 3'd6;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 16'd2048;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 16'd0;
  localparam logic [LIMIT_W-1:0] VEL_LIMIT_RST  = 31'd327680;
  localparam logic [DIST_W-1:0]  ARRIVE_SQ_RST  = 32'd5898;

  // Half the output LSB of the Q.12 sum, so the right shift rounds half up.
  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(2048);

  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic ld_c;
    logic integ_clr;
    logic integ_en;
    logic ld_d;
    logic ld_e;
    logic ld_f;
  } tapc_lane_ctl_t;

  typedef struct packed {
    logic valid;
    logic arrived;
    logic final_cmd;
  } tapc_res_t;

endpackage

// ----- design/tapc_if.sv -----
// Valid/ready channel interfaces for pose ticks and velocity commands.
`timescale 1ns / 1ps
interface tapc_in_if #(parameter int POS_WIDTH = 32) ();
  import tapc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [ACT_W-1:0]            action;
  logic signed [POS_WIDTH-1:0] pos_x;
  logic signed [POS_WIDTH-1:0] pos_y;
  logic signed [POS_WIDTH-1:0] pos_z;
  logic                        user_override;

  modport source (output valid, action, pos_x, pos_y, pos_z, user_override, input ready);
  modport sink (input valid, action, pos_x, pos_y, pos_z, user_override, output ready);
endinterface

interface tapc_out_if ();
  import tapc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] vel_z;
  logic                    arrived;
  logic                    final_cmd;

  modport source (output valid, vel_x, vel_y, vel_z, arrived, final_cmd, input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, arrived, final_cmd, output ready);
endinterface

// ----- design/tapc_lane.sv -----
// One axis lane: error, square, integrator, gain products and PI sum.
`timescale 1ns / 1ps
module tapc_lane #(
  parameter int POS_WIDTH   = 32,
  parameter int INTEG_WIDTH = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tapc_pkg::tapc_lane_ctl_t            ctl,
  input  logic signed [POS_WIDTH-1:0]         target,
  input  logic signed [POS_WIDTH-1:0]         pos,
  input  logic [tapc_pkg::GAIN_W-1:0]         prop_gain,
  input  logic [tapc_pkg::GAIN_W-1:0]         integ_gain,
  output logic                                small_err,
  output logic [tapc_pkg::SQ_W-1:0]           sq,
  output logic signed [tapc_pkg::SUM_W-1:0]   sum
);
  import tapc_pkg::*;

  localparam int EW     = POS_WIDTH + 1;
  localparam int SW     = ((INTEG_WIDTH > EW) ? INTEG_WIDTH : EW) + 1;
  localparam int PE_W   = EW + GAIN_W;
  localparam int PI_W   = INTEG_WIDTH + GAIN_W;
  localparam int MW0    = ((PE_W > PI_W) ? PE_W : PI_W);
  localparam int CLIP_W = (MW0 > PROD_W) ? MW0 : PROD_W;

  localparam logic signed [SW-1:0] IMAX =
    {{(SW - INTEG_WIDTH + 1){1'b0}}, {(INTEG_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] IMIN = ~IMAX;
  localparam logic [CLIP_W-1:0] CAP = CLIP_W'(1) << PROD_CAP_EXP;

  logic signed [EW-1:0]          a_e_r, b_e_r, c_e_r;
  logic signed [EW-1:0]          a_e_nxt;
  logic [EW-1:0]                 b_mag;
  logic [SMALL_W-1:0]            b_mag_lo;
  logic [SQ_W-1:0]               b_sq_r, b_sq_nxt;
  logic                          b_small_r, b_small_nxt;
  logic signed [SW-1:0]          isum;
  logic signed [SW-1:0]          isat;
  logic signed [INTEG_WIDTH-1:0] integ_r, integ_nxt;
  logic [EW-1:0]                 e_mag;
  logic [INTEG_WIDTH-1:0]        i_mag;
  logic [PE_W-1:0]               d_pe_r;
  logic [PI_W-1:0]               d_pi_r;
  logic                          d_ne_r, d_ni_r;
  logic signed [PROD_W-1:0]      e_p_r, e_q_r;
  logic signed [SUM_W-1:0]       f_s_r;

  // Magnitude is clipped to 2^60, then the sign is put back.
  function automatic logic signed [PROD_W-1:0] clip_sign(input logic [CLIP_W-1:0] m,
                                                         input logic neg);
    logic [CLIP_W-1:0]        c;
    logic signed [PROD_W-1:0] v;
    c = (m > CAP) ? CAP : m;
    v = $signed(PROD_W'(c));
    return neg ? -v : v;
  endfunction

  assign a_e_nxt = EW'(target) - EW'(pos);

  // The most negative error wraps to itself, which is its magnitude unsigned.
  assign b_mag       = a_e_r[EW-1] ? -a_e_r : a_e_r;
  assign b_small_nxt = (b_mag >> SMALL_W) == '0;
  assign b_mag_lo    = SMALL_W'(b_mag);
  assign b_sq_nxt    = SQ_W'(b_mag_lo) * SQ_W'(b_mag_lo);

  always_comb begin
    isum = SW'(integ_r) + SW'(b_e_r);
    if (isum > IMAX) begin
      isat = IMAX;
    end else if (isum < IMIN) begin
      isat = IMIN;
    end else begin
      isat = isum;
    end
    integ_nxt = isat[INTEG_WIDTH-1:0];
  end

  // The integrator only changes when an item enters stage C, so it still holds
  // the value left by the item that stage D is taking in.
  assign e_mag = c_e_r[EW-1] ? -c_e_r : c_e_r;
  assign i_mag = integ_r[INTEG_WIDTH-1] ? -integ_r : integ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (ctl.integ_clr) begin
      integ_r <= '0;
    end else if (ctl.integ_en) begin
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_a) begin
      a_e_r <= a_e_nxt;
    end
    if (ctl.ld_b) begin
      b_e_r     <= a_e_r;
      b_sq_r    <= b_sq_nxt;
      b_small_r <= b_small_nxt;
    end
    if (ctl.ld_c) begin
      c_e_r <= b_e_r;
    end
    if (ctl.ld_d) begin
      d_pe_r <= PE_W'(e_mag) * PE_W'(prop_gain);
      d_pi_r <= PI_W'(i_mag) * PI_W'(integ_gain);
      d_ne_r <= c_e_r[EW-1];
      d_ni_r <= integ_r[INTEG_WIDTH-1];
    end
    if (ctl.ld_e) begin
      e_p_r <= clip_sign(CLIP_W'(d_pe_r), d_ne_r);
      e_q_r <= clip_sign(CLIP_W'(d_pi_r), d_ni_r);
    end
    if (ctl.ld_f) begin
      f_s_r <= SUM_W'(e_p_r) + SUM_W'(e_q_r);
    end
  end

  assign small_err = b_small_r;
  assign sq        = b_sq_r;
  assign sum       = f_s_r;

endmodule

// ----- design/tapc_ctrl.sv -----
// Pipeline flow control, arrival test and mission state machine.
`timescale 1ns / 1ps
`include "three_axis_pi_position_controller_core_macros.svh"
module tapc_ctrl (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                in_valid,
  input  logic [tapc_pkg::ACT_W-1:0]                          in_action,
  input  logic                                                in_ovr,
  output logic                                                in_ready,
  input  logic                                                o_ld,
  input  logic [tapc_pkg::NAXES-1:0]                          small_err,
  input  logic [tapc_pkg::NAXES-1:0][tapc_pkg::SQ_W-1:0]      sq,
  input  logic [tapc_pkg::DIST_W-1:0]                         arrive_dist_sq,
  output tapc_pkg::tapc_lane_ctl_t                            lane_ctl,
  output tapc_pkg::tapc_res_t                                 res
);
  import tapc_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t           state_r, state_nxt;
  logic             reached_r, reached_nxt;
  logic             a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r;
  logic [ACT_W-1:0] a_act_r, b_act_r;
  logic             a_ovr_r, b_ovr_r;
  tapc_res_t        c_res_r, d_res_r, e_res_r, f_res_r, c_res_nxt;
  logic             ld_a, ld_b, ld_c, ld_d, ld_e, ld_f;
  logic             upd;
  logic             clr, integ;
  logic [SQSUM_W-1:0] sq_sum, thr;
  logic             arrive;

  // A stage takes a new transaction when it is empty or its own one moves on.
  assign ld_f     = !f_v_r || o_ld;
  assign ld_e     = !e_v_r || ld_f;
  assign ld_d     = !d_v_r || ld_e;
  assign ld_c     = !c_v_r || ld_d;
  assign ld_b     = !b_v_r || ld_c;
  assign ld_a     = !a_v_r || ld_b;
  assign in_ready = ld_a;
  assign upd      = ld_c && b_v_r;

  assign sq_sum = SQSUM_W'(sq[AX_X]) + SQSUM_W'(sq[AX_Y]) + SQSUM_W'(sq[AX_Z]);
  assign thr    = SQSUM_W'({arrive_dist_sq, {DIST_SHIFT{1'b0}}});
  assign arrive = (&small_err) && (sq_sum < thr);

  always_comb begin
    state_nxt   = state_r;
    reached_nxt = reached_r;
    c_res_nxt   = '0;
    clr         = 1'b0;
    integ       = 1'b0;
    case (b_act_r)
      ACT_START: begin
        state_nxt   = ST_RUN;
        reached_nxt = 1'b0;
        clr         = 1'b1;
      end
      ACT_STOP: begin
        if (state_r == ST_RUN) begin
          state_nxt           = ST_IDLE;
          c_res_nxt.valid     = 1'b1;
          c_res_nxt.arrived   = reached_r;
          c_res_nxt.final_cmd = 1'b1;
        end
      end
      ACT_TICK: begin
        if (state_r == ST_RUN) begin
          if (arrive) begin
            state_nxt           = ST_IDLE;
            reached_nxt         = 1'b1;
            c_res_nxt.valid     = 1'b1;
            c_res_nxt.arrived   = 1'b1;
            c_res_nxt.final_cmd = 1'b1;
          end else if (!b_ovr_r) begin
            integ           = 1'b1;
            c_res_nxt.valid = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      reached_r <= 1'b0;
      a_v_r     <= 1'b0;
      b_v_r     <= 1'b0;
      c_v_r     <= 1'b0;
      d_v_r     <= 1'b0;
      e_v_r     <= 1'b0;
      f_v_r     <= 1'b0;
      a_act_r   <= ACT_TICK;
      b_act_r   <= ACT_TICK;
      a_ovr_r   <= 1'b0;
      b_ovr_r   <= 1'b0;
      c_res_r   <= '0;
      d_res_r   <= '0;
      e_res_r   <= '0;
      f_res_r   <= '0;
    end else begin
      if (upd) begin
        state_r   <= state_nxt;
        reached_r <= reached_nxt;
      end
      if (ld_a) begin
        a_v_r   <= in_valid;
        a_act_r <= in_action;
        a_ovr_r <= in_ovr;
      end
      if (ld_b) begin
        b_v_r   <= a_v_r;
        b_act_r <= a_act_r;
        b_ovr_r <= a_ovr_r;
      end
      // Transactions that give no result leave the pipeline here.
      if (ld_c) begin
        c_v_r   <= b_v_r && c_res_nxt.valid;
        c_res_r <= c_res_nxt;
      end
      if (ld_d) begin
        d_v_r   <= c_v_r;
        d_res_r <= c_res_r;
      end
      if (ld_e) begin
        e_v_r   <= d_v_r;
        e_res_r <= d_res_r;
      end
      if (ld_f) begin
        f_v_r   <= e_v_r;
        f_res_r <= e_res_r;
      end
    end
  end

  always_comb begin
    lane_ctl.ld_a      = ld_a;
    lane_ctl.ld_b      = ld_b;
    lane_ctl.ld_c      = ld_c;
    lane_ctl.integ_clr = upd && clr;
    lane_ctl.integ_en  = upd && integ;
    lane_ctl.ld_d      = ld_d;
    lane_ctl.ld_e      = ld_e;
    lane_ctl.ld_f      = ld_f;
    res                = f_res_r;
    res.valid          = f_v_r;
  end

  `TAPC_ASSERT_IMPL(a_reached_idle, clk, rst_n, reached_r, state_r == ST_IDLE, "reached while running")
  `TAPC_ASSERT_NEXT(a_start_arms, clk, rst_n, upd && (b_act_r == ACT_START), (state_r == ST_RUN) && !reached_r, "start did not arm")
  `TAPC_ASSERT_IMPL(a_arrived_final, clk, rst_n, c_v_r && c_res_r.arrived, c_res_r.final_cmd, "arrival without final command")

endmodule

// ----- design/tapc_merge.sv -----
// Output stage: rounding, axis swap, saturation and the result register.
`timescale 1ns / 1ps
`include "three_axis_pi_position_controller_core_macros.svh"
module tapc_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tapc_pkg::tapc_res_t                 res,
  input  logic signed [tapc_pkg::SUM_W-1:0]   sum_x,
  input  logic signed [tapc_pkg::SUM_W-1:0]   sum_y,
  input  logic signed [tapc_pkg::SUM_W-1:0]   sum_z,
  input  logic [tapc_pkg::LIMIT_W-1:0]        velocity_limit,
  input  logic                                out_ready,
  output logic                                o_ld,
  output logic                                out_valid,
  output logic signed [tapc_pkg::VEL_W-1:0]   vel_x,
  output logic signed [tapc_pkg::VEL_W-1:0]   vel_y,
  output logic signed [tapc_pkg::VEL_W-1:0]   vel_z,
  output logic                                arrived,
  output logic                                final_cmd
);
  import tapc_pkg::*;

  localparam int RW = SUM_W - FRAC_SHIFT;

  logic                    o_v_r;
  logic                    o_arr_r, o_fin_r;
  logic signed [VEL_W-1:0] vel_x_r, vel_y_r, vel_z_r;
  logic signed [VEL_W-1:0] vel_x_nxt, vel_y_nxt, vel_z_nxt;
  logic signed [SUM_W-1:0] tx, ty, tz;
  logic signed [VEL_W-1:0] lim_pos, lim_neg;

  function automatic logic signed [VEL_W-1:0] shape(input logic signed [SUM_W-1:0] t,
                                                    input logic [LIMIT_W-1:0] lim);
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] lo;
    r  = RW'(t >>> FRAC_SHIFT);
    hi = $signed(RW'(lim));
    lo = -hi;
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return VEL_W'(r);
  endfunction

  // The new y command is the negated x sum, so the negation comes before rounding.
  assign tx = ROUND_BIAS - sum_x;
  assign ty = sum_y + ROUND_BIAS;
  assign tz = sum_z + ROUND_BIAS;

  always_comb begin
    if (res.final_cmd) begin
      vel_x_nxt = '0;
      vel_y_nxt = '0;
      vel_z_nxt = '0;
    end else begin
      vel_x_nxt = shape(ty, velocity_limit);
      vel_y_nxt = shape(tx, velocity_limit);
      vel_z_nxt = shape(tz, velocity_limit);
    end
  end

  assign o_ld = !o_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_ld) begin
      o_v_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ld) begin
      vel_x_r <= vel_x_nxt;
      vel_y_r <= vel_y_nxt;
      vel_z_r <= vel_z_nxt;
      o_arr_r <= res.arrived;
      o_fin_r <= res.final_cmd;
    end
  end

  assign out_valid = o_v_r;
  assign vel_x     = vel_x_r;
  assign vel_y     = vel_y_r;
  assign vel_z     = vel_z_r;
  assign arrived   = o_arr_r;
  assign final_cmd = o_fin_r;

  assign lim_pos = $signed(VEL_W'(velocity_limit));
  assign lim_neg = -lim_pos;

  `TAPC_ASSERT_IMPL(a_final_zero, clk, rst_n, o_v_r && o_fin_r, (vel_x_r == '0) && (vel_y_r == '0) && (vel_z_r == '0), "final command not zero")
  `TAPC_ASSERT_IMPL(a_vel_limit, clk, rst_n, o_v_r && !o_fin_r, (vel_x_r <= lim_pos) && (vel_x_r >= lim_neg) && (vel_y_r <= lim_pos) && (vel_y_r >= lim_neg) && (vel_z_r <= lim_pos) && (vel_z_r >= lim_neg), "velocity beyond limit")

endmodule

// ----- design/three_axis_pi_position_controller_core.sv -----
// Throughput: one transaction per cycle while the command receiver does not stall;
// three axis lanes run side by side in a seven-register pipeline (error, square,
// decision, multiply, clip, sum, output).
// Transactions that give no command drop out at the decision stage.
// Reset (synchronous, rst_n low): mission idle, integrators cleared, pipeline
// empty, configuration registers back to their default values.
`timescale 1ns / 1ps
module three_axis_pi_position_controller_core #(
  parameter int POS_WIDTH   = 32,
  parameter int INTEG_WIDTH = 48
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  tapc_in_if.sink                                  in_ch,
  tapc_out_if.source                               out_ch,
  input  logic                                     cfg_we,
  input  logic [tapc_pkg::CFG_IDX_W-1:0]           cfg_idx,
  input  logic [((POS_WIDTH > tapc_pkg::DIST_W) ? POS_WIDTH : tapc_pkg::DIST_W)-1:0] cfg_data
);
  import tapc_pkg::*;

  logic signed [POS_WIDTH-1:0]     tgt_x_r, tgt_y_r, tgt_z_r;
  logic [GAIN_W-1:0]               prop_gain_r, integ_gain_r;
  logic [LIMIT_W-1:0]              vel_limit_r;
  logic [DIST_W-1:0]               arrive_r;
  tapc_lane_ctl_t                  lane_ctl;
  tapc_res_t                       res;
  logic                            o_ld;
  logic                            in_ready;
  logic [NAXES-1:0]                small_err;
  logic [NAXES-1:0][SQ_W-1:0]      sq;
  logic signed [SUM_W-1:0]         sum_x, sum_y, sum_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_x_r      <= '0;
      tgt_y_r      <= '0;
      tgt_z_r      <= '0;
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      vel_limit_r  <= VEL_LIMIT_RST;
      arrive_r     <= ARRIVE_SQ_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TARGET_X:   tgt_x_r      <= POS_WIDTH'(cfg_data);
        REG_TARGET_Y:   tgt_y_r      <= POS_WIDTH'(cfg_data);
        REG_TARGET_Z:   tgt_z_r      <= POS_WIDTH'(cfg_data);
        REG_PROP_GAIN:  prop_gain_r  <= GAIN_W'(cfg_data);
        REG_INTEG_GAIN: integ_gain_r <= GAIN_W'(cfg_data);
        REG_VEL_LIMIT:  vel_limit_r  <= LIMIT_W'(cfg_data);
        REG_ARRIVE_SQ:  arrive_r     <= DIST_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = in_ready;

  tapc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_action      (in_ch.action),
    .in_ovr         (in_ch.user_override),
    .in_ready       (in_ready),
    .o_ld           (o_ld),
    .small_err      (small_err),
    .sq             (sq),
    .arrive_dist_sq (arrive_r),
    .lane_ctl       (lane_ctl),
    .res            (res)
  );

  tapc_lane #(.POS_WIDTH(POS_WIDTH), .INTEG_WIDTH(INTEG_WIDTH)) u_lane_x (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (lane_ctl),
    .target     (tgt_x_r),
    .pos        (in_ch.pos_x),
    .prop_gain  (prop_gain_r),
    .integ_gain (integ_gain_r),
    .small_err  (small_err[AX_X]),
    .sq         (sq[AX_X]),
    .sum        (sum_x)
  );

  tapc_lane #(.POS_WIDTH(POS_WIDTH), .INTEG_WIDTH(INTEG_WIDTH)) u_lane_y (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (lane_ctl),
    .target     (tgt_y_r),
    .pos        (in_ch.pos_y),
    .prop_gain  (prop_gain_r),
    .integ_gain (integ_gain_r),
    .small_err  (small_err[AX_Y]),
    .sq         (sq[AX_Y]),
    .sum        (sum_y)
  );

  tapc_lane #(.POS_WIDTH(POS_WIDTH), .INTEG_WIDTH(INTEG_WIDTH)) u_lane_z (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (lane_ctl),
    .target     (tgt_z_r),
    .pos        (in_ch.pos_z),
    .prop_gain  (prop_gain_r),
    .integ_gain (integ_gain_r),
    .small_err  (small_err[AX_Z]),
    .sq         (sq[AX_Z]),
    .sum        (sum_z)
  );

  tapc_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .res            (res),
    .sum_x          (sum_x),
    .sum_y          (sum_y),
    .sum_z          (sum_z),
    .velocity_limit (vel_limit_r),
    .out_ready      (out_ch.ready),
    .o_ld           (o_ld),
    .out_valid      (out_ch.valid),
    .vel_x          (out_ch.vel_x),
    .vel_y          (out_ch.vel_y),
    .vel_z          (out_ch.vel_z),
    .arrived        (out_ch.arrived),
    .final_cmd      (out_ch.final_cmd)
  );

endmodule

// ----- verif/position_command_checker.sv -----
// Checker that predicts velocity commands from pose transactions and compares them.
`timescale 1ns / 1ps
module position_command_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  tapc_in_if                             in_mon,
  tapc_out_if                            out_mon,
  input  logic                           cfg_we,
  input  logic [tapc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]                    cfg_data,
  output int                             fail_count,
  output int                             pending_count,
  output int                             cmd_count,
  output int                             closing_count
);
  import tapc_pkg::*;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic               arrived;
    logic               final_cmd;
  } vel_cmd_t;

  localparam longint ACC_MAX = (64'sd1 <<< 47) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint unsigned PROD_CAP = 64'd1 << 60;
  localparam longint unsigned NEAR_LIMIT = 64'd1 << 24;

  // Mirrored configuration and mission state.
  longint          tgt_x, tgt_y, tgt_z;
  longint unsigned kp, ki, vlim, arrive_sq;
  bit              mission_on, target_hit;
  longint          acc_x, acc_y, acc_z;

  vel_cmd_t pending_cmds[$];
  int       errs, cmds, closings;

  function automatic longint sat_accumulate(input longint acc, input longint e);
    longint sum;
    sum = acc + e;
    if (sum > ACC_MAX) return ACC_MAX;
    if (sum < ACC_MIN) return ACC_MIN;
    return sum;
  endfunction

  function automatic longint gain_product(input longint v, input longint unsigned g);
    longint unsigned m, p;
    m = (v < 0) ? -v : v;
    if (g != 0 && m > PROD_CAP / g) p = PROD_CAP;
    else p = m * g;
    return (v < 0) ? -$signed(p) : $signed(p);
  endfunction

  // Drop the 12 gain fraction bits, rounding half up, then clamp to the limit.
  function automatic logic signed [31:0] shape_velocity(input longint s);
    longint r, lim;
    lim = longint'(vlim);
    r = (s + 2048) >>> 12;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[31:0];
  endfunction

  function automatic bit near_axis(input longint e, output longint unsigned sq);
    longint unsigned m;
    m = (e < 0) ? -e : e;
    sq = m * m;
    return m < NEAR_LIMIT;
  endfunction

  function automatic bit predict_command(input logic [1:0] act, input logic signed [31:0] px,
                                         input logic signed [31:0] py,
                                         input logic signed [31:0] pz, input logic ovr,
                                         output vel_cmd_t cmd);
    longint          ex, ey, ez, sx, sy, sz;
    longint unsigned qx, qy, qz;
    bit              hit;
    cmd = '0;
    case (act)
      ACT_START: begin
        mission_on = 1'b1;
        target_hit = 1'b0;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        return 1'b0;
      end
      ACT_STOP: begin
        if (!mission_on) return 1'b0;
        mission_on = 1'b0;
        cmd.arrived = target_hit;
        cmd.final_cmd = 1'b1;
        return 1'b1;
      end
      ACT_TICK: ;
      default: return 1'b0;
    endcase
    if (!mission_on) return 1'b0;

    ex = tgt_x - longint'(px);
    ey = tgt_y - longint'(py);
    ez = tgt_z - longint'(pz);
    hit = near_axis(ex, qx);
    hit = near_axis(ey, qy) && hit;
    hit = near_axis(ez, qz) && hit;
    // Arrival closes the mission even while the operator holds control.
    if (hit && (qx + qy + qz) < (arrive_sq << 16)) begin
      target_hit = 1'b1;
      mission_on = 1'b0;
      cmd.arrived = 1'b1;
      cmd.final_cmd = 1'b1;
      return 1'b1;
    end
    if (ovr) return 1'b0;

    acc_x = sat_accumulate(acc_x, ex);
    acc_y = sat_accumulate(acc_y, ey);
    acc_z = sat_accumulate(acc_z, ez);
    sx = gain_product(ex, kp) + gain_product(acc_x, ki);
    sy = gain_product(ey, kp) + gain_product(acc_y, ki);
    sz = gain_product(ez, kp) + gain_product(acc_z, ki);
    // The vehicle frame swaps the horizontal axes.
    cmd.vx = shape_velocity(sy);
    cmd.vy = shape_velocity(-sx);
    cmd.vz = shape_velocity(sz);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    vel_cmd_t exp_cmd, got;
    if (!rst_n) begin
      tgt_x = 0;
      tgt_y = 0;
      tgt_z = 0;
      kp = PROP_GAIN_RST;
      ki = INTEG_GAIN_RST;
      vlim = VEL_LIMIT_RST;
      arrive_sq = ARRIVE_SQ_RST;
      mission_on = 1'b0;
      target_hit = 1'b0;
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      pending_cmds.delete();
      errs = 0;
      cmds = 0;
      closings = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_TARGET_X:   tgt_x = longint'($signed(cfg_data));
          REG_TARGET_Y:   tgt_y = longint'($signed(cfg_data));
          REG_TARGET_Z:   tgt_z = longint'($signed(cfg_data));
          REG_PROP_GAIN:  kp = cfg_data[15:0];
          REG_INTEG_GAIN: ki = cfg_data[15:0];
          REG_VEL_LIMIT:  vlim = cfg_data[30:0];
          REG_ARRIVE_SQ:  arrive_sq = cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (predict_command(in_mon.action, in_mon.pos_x, in_mon.pos_y, in_mon.pos_z,
                            in_mon.user_override, exp_cmd))
          pending_cmds = {pending_cmds, exp_cmd};
      end
      if (out_mon.valid && out_mon.ready) begin
        got.vx = out_mon.vel_x;
        got.vy = out_mon.vel_y;
        got.vz = out_mon.vel_z;
        got.arrived = out_mon.arrived;
        got.final_cmd = out_mon.final_cmd;
        cmds++;
        if (got.final_cmd) closings++;
        if (pending_cmds.size() == 0) begin
          if (errs < 10)
            $display("%0t: command vel=(%0d %0d %0d) arr=%b fin=%b with nothing predicted",
                     $realtime, got.vx, got.vy, got.vz, got.arrived, got.final_cmd);
          errs++;
        end else begin
          exp_cmd = pending_cmds.pop_front();
          if (got.vx !== exp_cmd.vx || got.vy !== exp_cmd.vy || got.vz !== exp_cmd.vz ||
              got.arrived !== exp_cmd.arrived || got.final_cmd !== exp_cmd.final_cmd) begin
            if (errs < 10)
              $display("%0t: expected vel=(%0d %0d %0d) arr=%b fin=%b, got (%0d %0d %0d) arr=%b fin=%b",
                       $realtime, exp_cmd.vx, exp_cmd.vy, exp_cmd.vz, exp_cmd.arrived,
                       exp_cmd.final_cmd, got.vx, got.vy, got.vz, got.arrived, got.final_cmd);
            errs++;
          end
        end
      end
    end
    fail_count    <= errs;
    pending_count <= pending_cmds.size();
    cmd_count     <= cmds;
    closing_count <= closings;
  end

endmodule

// ----- verif/testbench.sv -----
// Top-level testbench: drives missions and register settings into the position controller.
`timescale 1ns / 1ps
module testbench;
  import tapc_pkg::*;

  localparam int MODE_NEAR     = 0;
  localparam int MODE_FAR      = 1;
  localparam int MODE_BOUNDARY = 2;
  localparam int MODE_WILD     = 3;
  localparam int SETTLE_CYCLES = 12;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [31:0]          cfg_data;

  tapc_in_if #(.POS_WIDTH(32)) in_bus ();
  tapc_out_if                  out_bus ();

  int fail_count, pending_count, cmd_count, closing_count;
  int items_sent = 0;
  int settings_used = 1;
  int hold_left = 0;
  int drain_stall = 0;
  bit feed_gaps = 1'b1;
  bit drain_gaps = 1'b1;
  logic signed [31:0] aim [3];

  three_axis_pi_position_controller_core #(.POS_WIDTH(32), .INTEG_WIDTH(48)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  position_command_checker cmd_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .cmd_count     (cmd_count),
    .closing_count (closing_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("three_axis_pi_position_controller_core: mismatch");
    $finish;
  end

  // Command receiver: random stall after each transaction, plus long hold-offs on request.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready && drain_gaps) drain_stall = $urandom_range(0, 13);
      out_bus.ready <= (hold_left == 0) && (drain_stall == 0);
      if (hold_left > 0) hold_left--;
      if (drain_stall > 0) drain_stall--;
    end
  end

  task automatic send_item(input logic [1:0] act, input logic signed [31:0] px,
                           input logic signed [31:0] py, input logic signed [31:0] pz,
                           input logic ovr);
    int gap;
    gap = feed_gaps ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.action        <= act;
    in_bus.pos_x         <= px;
    in_bus.pos_y         <= py;
    in_bus.pos_z         <= pz;
    in_bus.user_override <= ovr;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
  endtask

  // Wait for every predicted command, then let dropped transactions leave the pipeline.
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic set_config(input logic signed [31:0] tx, input logic signed [31:0] ty,
                            input logic signed [31:0] tz, input logic [15:0] kp,
                            input logic [15:0] ki, input logic [30:0] lim,
                            input logic [31:0] dsq);
    write_reg(REG_TARGET_X, tx);
    write_reg(REG_TARGET_Y, ty);
    write_reg(REG_TARGET_Z, tz);
    write_reg(REG_PROP_GAIN, 32'(kp));
    write_reg(REG_INTEG_GAIN, 32'(ki));
    write_reg(REG_VEL_LIMIT, 32'(lim));
    write_reg(REG_ARRIVE_SQ, dsq);
    cfg_we <= 1'b0;
    aim[0] = tx;
    aim[1] = ty;
    aim[2] = tz;
    settings_used++;
  endtask

  // Error offset from the target on one axis; boundary mode puts one axis around the 2^24 limit.
  function automatic int pick_offset(input int mode, input bit on_lane);
    int mag;
    case (mode)
      MODE_NEAR: return int'($urandom_range(0, 40000)) - 20000;
      MODE_FAR:  return int'($urandom_range(0, 4000000)) - 2000000;
      MODE_BOUNDARY: begin
        if (!on_lane) return int'($urandom_range(0, 200)) - 100;
        mag = (1 << 24) - 1 + int'($urandom_range(0, 2));
        return $urandom_range(0, 1) ? mag : -mag;
      end
      default: return int'($urandom);
    endcase
  endfunction

  task automatic pose_tick(input int mode, input logic ovr);
    logic signed [31:0] p [3];
    int lane;
    lane = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) p[i] = aim[i] - pick_offset(mode, i == lane);
    send_item(ACT_TICK, p[0], p[1], p[2], ovr);
  endtask

  // Mostly well-formed missions with random poses, some stray transactions between them.
  task automatic run_missions(input int quota);
    int n, len, r;
    n = 0;
    while (n < quota) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                  1'($urandom_range(0, 1)));
        n++;
      end else begin
        send_item(ACT_START, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        n++;
        len = $urandom_range(1, 12);
        repeat (len) begin
          r = $urandom_range(0, 99);
          pose_tick(r < 18 ? MODE_NEAR : r < 28 ? MODE_BOUNDARY : r < 94 ? MODE_FAR : MODE_WILD,
                    $urandom_range(0, 99) < 15);
          n++;
        end
        if ($urandom_range(0, 99) < 70) begin
          send_item(ACT_STOP, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
          n++;
        end
      end
    end
    settle();
  endtask

  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= '0;
    cfg_data             <= '0;
    in_bus.valid         <= 1'b0;
    in_bus.action        <= ACT_TICK;
    in_bus.pos_x         <= '0;
    in_bus.pos_y         <= '0;
    in_bus.pos_z         <= '0;
    in_bus.user_override <= 1'b0;
    aim[0] = 0;
    aim[1] = 0;
    aim[2] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset configuration.
    send_item(ACT_TICK, 0, 0, 0, 1'b0);
    send_item(ACT_STOP, 0, 0, 0, 1'b0);
    send_item(2'd3, -1, -1, -1, 1'b1);
    send_item(ACT_START, 0, 0, 0, 1'b0);
    send_item(ACT_TICK, 1000000, 1000000, 1000000, 1'b1);
    send_item(ACT_TICK, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_item(ACT_TICK, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
    send_item(ACT_TICK, -200000, 300000, 50000, 1'b0);
    // One LSB outside the default arrival radius, then an arrival under override.
    send_item(ACT_TICK, 19661, 0, 0, 1'b0);
    send_item(ACT_TICK, 100, 0, 0, 1'b1);
    send_item(ACT_STOP, 0, 0, 0, 1'b0);
    send_item(ACT_START, 0, 0, 0, 1'b0);
    send_item(ACT_TICK, 32'sh12345, -77777, 5, 1'b0);
    send_item(ACT_START, 0, 0, 0, 1'b0);
    send_item(ACT_TICK, -5000000, 0, 0, 1'b0);
    send_item(ACT_STOP, 0, 0, 0, 1'b0);
    send_item(ACT_START, 0, 0, 0, 1'b0);
    send_item(ACT_TICK, 19660, 0, 0, 1'b0);
    send_item(ACT_TICK, 0, 0, 0, 1'b0);
    settle();

    run_missions(80);

    set_config(int'($urandom_range(0, 2000000)) - 1000000,
               int'($urandom_range(0, 2000000)) - 1000000,
               int'($urandom_range(0, 2000000)) - 1000000,
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 400)),
               VEL_LIMIT_RST, ARRIVE_SQ_RST);
    run_missions(90);

    set_config(32'sh80000000, 32'sh7fffffff, 0, 16'hffff, 16'hffff, 31'h7fffffff,
               32'hffffffff);
    run_missions(90);

    set_config(0, 0, 0, 16'h0000, 16'h0000, 31'h0, 32'h0);
    run_missions(60);

    set_config($urandom, $urandom, $urandom, 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 31'($urandom_range(0, 32'h7fffffff)), $urandom);
    run_missions(90);

    // A stretch without idling on either side.
    feed_gaps  = 1'b0;
    drain_gaps = 1'b0;
    set_config(int'($urandom_range(0, 600000)) - 300000, 0, int'($urandom_range(0, 600000)),
               16'($urandom_range(0, 16384)), 16'($urandom_range(0, 2000)),
               31'($urandom_range(0, 1 << 22)), 32'($urandom_range(0, 200000)));
    run_missions(90);

    // The receiver holds off while ticks keep coming, so the pipeline backs up.
    set_config(0, 0, 0, 16'd4096, 16'd100, 31'd1 << 20, ARRIVE_SQ_RST);
    send_item(ACT_START, 0, 0, 0, 1'b0);
    hold_left = 300;
    repeat (40) pose_tick(MODE_FAR, 1'b0);
    settle();

    feed_gaps  = 1'b1;
    drain_gaps = 1'b1;
    set_config($urandom, $urandom, $urandom, 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 3000)), 31'($urandom_range(0, 32'h7fffffff)),
               32'($urandom_range(0, 1000000)));
    run_missions(80);

    $display("Sent %0d transactions under %0d register settings.", items_sent, settings_used);
    $display("Checked %0d velocity commands, %0d of them closing a mission.",
             cmd_count, closing_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("three_axis_pi_position_controller_core: match");
    end else begin
      $display("three_axis_pi_position_controller_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/tapc_pkg.sv
design/tapc_if.sv
design/tapc_lane.sv
design/tapc_ctrl.sv
design/tapc_merge.sv
design/three_axis_pi_position_controller_core.sv
verif/position_command_checker.sv
verif/testbench.sv
